/* src/pre_post_trigger_frame_capture_core_macros.svh */
// assertion macros for the pre/post trigger frame capture core
// no dependencies; included by the top level, the only module that carries assertions
`ifndef PRE_POST_TRIGGER_FRAME_CAPTURE_CORE_MACROS_SVH
`define PRE_POST_TRIGGER_FRAME_CAPTURE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PPTFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PPTFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pptfc_pkg.sv */
// shared types and codes for the pre/post trigger frame capture core
// no dependencies
`default_nettype none

package pptfc_pkg;

  // ring pointers and fill count width (also the width of the pre_count register)
  localparam int CNT_W = 6;
  localparam int CTR_W = 16;
  localparam int CFG_W = 16;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_SOFT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PRE_COUNT  = 2'd0,
    REG_POST_COUNT = 2'd1,
    REG_PRESET     = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_FILL  = 3'd1,
    ST_WRAP  = 3'd2,
    ST_FLUSH = 3'd3,
    ST_DONE  = 3'd4
  } status_t;

  // capture context held in flops
  typedef struct packed {
    logic [CNT_W-1:0] head;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap;
    logic             running;
    logic             trig;
    logic             soft_pend;
    logic             flushed;
    logic [CTR_W-1:0] post_cnt;
    logic [CTR_W-1:0] cap_cnt;
    status_t          status;
  } ctx_t;

  // step decision handed to the sequencer
  typedef struct packed {
    ctx_t             nxt;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic             emit;
    logic             flush;
    logic [CNT_W-1:0] flush_head;
    logic [CNT_W-1:0] flush_len;
  } step_t;

  localparam ctx_t CTX_RESET = '{
    head:      '0,
    count:     '0,
    cap:       '0,
    running:   1'b0,
    trig:      1'b0,
    soft_pend: 1'b0,
    flushed:   1'b0,
    post_cnt:  '0,
    cap_cnt:   '0,
    status:    ST_IDLE
  };

endpackage

`default_nettype wire

/* src/pptfc_ring.sv */
// pre-trigger ring storage: one write port, one registered read port
// no package dependencies
`default_nettype none

module pptfc_ring #(
  parameter int DEPTH = 63,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/pptfc_step.sv */
// per-item next-state logic: ring write slot, trigger, flush and capture end
// depends on pptfc_pkg
`default_nettype none

module pptfc_step
  import pptfc_pkg::*;
#(
  parameter int RING_DEPTH = 63
) (
  input  wire ctx_t              ctx,
  input  wire cmd_t              cmd,
  input  wire logic              hit,
  input  wire logic [CNT_W-1:0]  pre_count,
  input  wire logic [CTR_W-1:0]  post_count,
  input  wire logic [CTR_W-1:0]  preset_captures,
  output step_t                  st
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);

  logic           trig;
  logic [CNT_W:0] wsum;
  ctx_t           n;

  always_comb begin
    n             = ctx;
    trig          = 1'b0;
    wsum          = '0;
    st.wr_en      = 1'b0;
    st.wr_idx     = '0;
    st.emit       = 1'b0;
    st.flush      = 1'b0;
    st.flush_head = '0;
    st.flush_len  = '0;

    unique case (cmd)
      CMD_START: begin
        n.cap       = (pre_count > DEPTH_C) ? DEPTH_C : pre_count;
        n.head      = '0;
        n.count     = '0;
        n.flushed   = 1'b0;
        n.soft_pend = 1'b0;
        n.trig      = 1'b0;
        n.post_cnt  = '0;
        n.cap_cnt   = '0;
        n.running   = 1'b1;
        n.status    = ST_FILL;
      end
      CMD_STOP: begin
        n.running   = 1'b0;
        n.soft_pend = 1'b0;
        n.trig      = 1'b0;
        n.count     = '0;
        n.head      = '0;
        n.status    = ST_IDLE;
      end
      CMD_SOFT: begin
        n.soft_pend = 1'b1;
        n.trig      = 1'b1;
      end
      CMD_FRAME: begin
        if (ctx.running) begin
          trig   = ctx.soft_pend | ctx.trig | hit;
          n.trig = trig;
          if (!trig) begin
            // pre-trigger: append, or overwrite oldest once full
            if (ctx.cap != '0) begin
              if (ctx.count < ctx.cap) begin
                wsum = {1'b0, ctx.head} + {1'b0, ctx.count};
                if (wsum >= {1'b0, ctx.cap}) begin
                  wsum = wsum - {1'b0, ctx.cap};
                end
                st.wr_en  = 1'b1;
                st.wr_idx = wsum[CNT_W-1:0];
                n.count   = ctx.count + CNT_W'(1);
              end else begin
                st.wr_en  = 1'b1;
                st.wr_idx = ctx.head;
                n.head    = (ctx.head + CNT_W'(1) == ctx.cap) ? '0 : ctx.head + CNT_W'(1);
              end
            end
            if (n.count == n.cap) begin
              n.status = ST_WRAP;
            end
          end else begin
            // triggered: dump the ring once, then pass the frame
            n.status = ST_FLUSH;
            if (!ctx.flushed) begin
              n.flushed     = 1'b1;
              st.flush      = (ctx.count != '0) && (ctx.cap != '0);
              st.flush_head = ctx.head;
              st.flush_len  = ctx.count;
              n.count       = '0;
              n.head        = '0;
            end
            if (ctx.post_cnt != '1) begin
              n.post_cnt = ctx.post_cnt + CTR_W'(1);
            end
            st.emit = 1'b1;
          end
          // end of capture: re-arm or finish
          if (n.post_cnt >= post_count) begin
            if (ctx.cap_cnt != '1) begin
              n.cap_cnt = ctx.cap_cnt + CTR_W'(1);
            end
            if ((preset_captures == '0) || (n.cap_cnt < preset_captures)) begin
              n.flushed   = 1'b0;
              n.soft_pend = 1'b0;
              n.trig      = 1'b0;
              n.post_cnt  = '0;
              n.status    = ST_FILL;
            end else begin
              n.trig    = 1'b0;
              n.running = 1'b0;
              n.status  = ST_DONE;
            end
          end
        end
      end
    endcase

    st.nxt = n;
  end

endmodule

`default_nettype wire

/* src/pre_post_trigger_frame_capture_core.sv */
// top level of the pre/post trigger frame capture core
// depends on pptfc_pkg, pptfc_step, pptfc_ring and the assertion macro header
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  command   | cmd, frame_handle, trigger_hit            | start & !busy
//  result    | out_valid, out_handle, last, status, ...  | strobe, one cycle, no stall
//  config    | cfg_index, cfg_data                       | cfg_we
//
// An ordinary item's single result is registered and shows in the next cycle, and busy
// stays low, so items may follow every cycle. A trigger frame with n frames held in the
// ring keeps busy high while the ring memory is read one entry a cycle through its one
// registered read port; its n + 1 results come on consecutive cycles. Reset is synchronous;
// no clearing pass is needed since only written ring entries are ever read. Results cannot
// be stalled.
`default_nettype none

`include "pre_post_trigger_frame_capture_core_macros.svh"

module pre_post_trigger_frame_capture_core
  import pptfc_pkg::*;
#(
  parameter int RING_DEPTH  = 63,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             cmd,
  input  wire logic [HANDLE_BITS-1:0] frame_handle,
  input  wire logic                   trigger_hit,
  output logic                        strobe,
  output logic                        out_valid,
  output logic [HANDLE_BITS-1:0]      out_handle,
  output logic                        last,
  output logic [2:0]                  status,
  output logic [CNT_W-1:0]            ring_fill,
  output logic [CTR_W-1:0]            post_done,
  output logic [CTR_W-1:0]            captures_done,
  output logic                        triggered_flag,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FLUSH = 2'b10
  } fsm_t;

  fsm_t                   fsm;
  ctx_t                   ctx;
  step_t                  st;
  logic                   accept;
  logic [CNT_W-1:0]       pre_count;
  logic [CTR_W-1:0]       post_count;
  logic [CTR_W-1:0]       preset_captures;
  logic [CNT_W-1:0]       flush_left;
  logic [CNT_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       rd_ptr_next;
  logic                   rd_en;
  logic                   rd_vld;
  logic [HANDLE_BITS-1:0] rd_data;
  logic [HANDLE_BITS-1:0] trig_handle;
  logic                   ring_wr_en;

  assign busy   = (fsm == S_FLUSH);
  assign accept = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_count       <= CNT_W'(63);
      post_count      <= CTR_W'(100);
      preset_captures <= CTR_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRE_COUNT:  pre_count       <= cfg_data[CNT_W-1:0];
        REG_POST_COUNT: post_count      <= cfg_data[CTR_W-1:0];
        REG_PRESET:     preset_captures <= cfg_data[CTR_W-1:0];
        REG_UNUSED:     ;
      endcase
    end
  end

  // per-item decision
  pptfc_step #(
    .RING_DEPTH(RING_DEPTH)
  ) u_step (
    .ctx             (ctx),
    .cmd             (cmd_t'(cmd)),
    .hit             (trigger_hit),
    .pre_count       (pre_count),
    .post_count      (post_count),
    .preset_captures (preset_captures),
    .st              (st)
  );

  // ring memory
  assign ring_wr_en  = accept & st.wr_en;
  assign rd_en       = (fsm == S_FLUSH) && (flush_left != '0);
  assign rd_ptr_next = (rd_ptr + CNT_W'(1) == ctx.cap) ? '0 : rd_ptr + CNT_W'(1);

  pptfc_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (HANDLE_BITS),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (st.wr_idx[AW-1:0]),
    .wr_data (frame_handle),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  // sequencer: context update, ring walk and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= S_IDLE;
      ctx        <= CTX_RESET;
      strobe     <= 1'b0;
      rd_vld     <= 1'b0;
      flush_left <= '0;
    end else begin
      rd_vld <= rd_en;
      unique case (fsm)
        S_IDLE: begin
          if (accept) begin
            ctx <= st.nxt;
            if (st.flush) begin
              fsm         <= S_FLUSH;
              flush_left  <= st.flush_len;
              rd_ptr      <= st.flush_head;
              trig_handle <= frame_handle;
              strobe      <= 1'b0;
            end else begin
              strobe     <= 1'b1;
              out_valid  <= st.emit;
              out_handle <= st.emit ? frame_handle : '0;
              last       <= 1'b1;
            end
          end else begin
            strobe <= 1'b0;
          end
        end
        S_FLUSH: begin
          if (rd_en) begin
            flush_left <= flush_left - CNT_W'(1);
            rd_ptr     <= rd_ptr_next;
          end
          if (rd_vld) begin
            strobe     <= 1'b1;
            out_valid  <= 1'b1;
            out_handle <= rd_data;
            last       <= 1'b0;
          end else if (flush_left == '0) begin
            strobe     <= 1'b1;
            out_valid  <= 1'b1;
            out_handle <= trig_handle;
            last       <= 1'b1;
            fsm        <= S_IDLE;
          end else begin
            strobe <= 1'b0;
          end
        end
        default: begin
          fsm    <= S_IDLE;
          strobe <= 1'b0;
        end
      endcase
    end
  end

  // status fields reflect the context after the whole item
  assign status         = ctx.status;
  assign ring_fill      = ctx.count;
  assign post_done      = ctx.post_cnt;
  assign captures_done  = ctx.cap_cnt;
  assign triggered_flag = ctx.trig;

  // checks
  `PPTFC_ASSERT_NOW(a_no_write_in_flush, clk, rst, fsm == S_FLUSH, !ring_wr_en, "ring written during flush")
  `PPTFC_ASSERT_NOW(a_fill_in_cap, clk, rst, 1'b1, ctx.count <= ctx.cap, "ring fill above capacity")
  `PPTFC_ASSERT_NOW(a_idle_handle_zero, clk, rst, strobe && !out_valid, out_handle == '0, "empty result carries a handle")
  `PPTFC_ASSERT_NEXT(a_read_emits, clk, rst, rd_vld, strobe && out_valid && !last, "ring read not emitted")
  `PPTFC_ASSERT_NEXT(a_flush_start_quiet, clk, rst, accept && st.flush, busy && !strobe, "flush start without walk")

endmodule

`default_nettype wire

/* dv/tb_pre_post_trigger_frame_capture_core.sv */
// self-checking testbench for pre_post_trigger_frame_capture_core
// predicts every result of the capture core in-line and compares each strobed result
// depends on pptfc_pkg and the core itself
module tb_pre_post_trigger_frame_capture_core
  import pptfc_pkg::*;
();

  localparam int RING_MAX    = 63;
  localparam int CNT_MAX     = 65535;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    cmd_t        op;
    logic [15:0] handle;
    logic        hit;
  } cmd_item_t;

  typedef struct {
    logic        valid;
    logic [15:0] handle;
    logic        last;
    status_t     status;
    int          fill;
    int          post;
    int          caps;
    logic        trig;
  } capture_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = CMD_FRAME;
  logic [15:0] frame_handle = '0;
  logic        trigger_hit = 1'b0;
  logic        strobe;
  logic        out_valid;
  logic [15:0] out_handle;
  logic        last;
  logic [2:0]  status;
  logic [5:0]  ring_fill;
  logic [15:0] post_done;
  logic [15:0] captures_done;
  logic        triggered_flag;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_PRE_COUNT;
  logic [15:0] cfg_data = '0;

  cmd_item_t       cmd_backlog[$];
  capture_result_t expected_results[$];
  int              mismatch_cnt = 0;
  int              cycle_cnt = 0;
  bit              no_idle = 1'b0;

  // predictor copy of the configuration registers
  int pre_cfg = 63;
  int post_cfg = 100;
  int preset_cfg = 1;

  // predictor copy of the capture state
  logic [15:0] ring_mem [0:RING_MAX-1];
  int      head_q = 0;
  int      fill_q = 0;
  int      cap_q = 0;
  bit      run_q = 0;
  bit      trig_q = 0;
  bit      soft_q = 0;
  bit      flushed_q = 0;
  int      post_q = 0;
  int      caps_q = 0;
  status_t stat_q = ST_IDLE;

  pre_post_trigger_frame_capture_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .frame_handle   (frame_handle),
    .trigger_hit    (trigger_hit),
    .strobe         (strobe),
    .out_valid      (out_valid),
    .out_handle     (out_handle),
    .last           (last),
    .status         (status),
    .ring_fill      (ring_fill),
    .post_done      (post_done),
    .captures_done  (captures_done),
    .triggered_flag (triggered_flag),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // advance the capture state by one command and queue the results it causes
  task automatic capture_predict(cmd_t op, logic [15:0] h, logic hit);
    logic [15:0]     emitted[$];
    capture_result_t res;
    bit              trig;
    int              i;
    case (op)
      CMD_START: begin
        cap_q     = pre_cfg > RING_MAX ? RING_MAX : pre_cfg;
        head_q    = 0;
        fill_q    = 0;
        flushed_q = 0;
        soft_q    = 0;
        trig_q    = 0;
        post_q    = 0;
        caps_q    = 0;
        run_q     = 1;
        stat_q    = ST_FILL;
      end
      CMD_STOP: begin
        run_q  = 0;
        soft_q = 0;
        trig_q = 0;
        fill_q = 0;
        head_q = 0;
        stat_q = ST_IDLE;
      end
      CMD_SOFT: begin
        soft_q = 1;
        trig_q = 1;
      end
      default: begin
        if (run_q) begin
          trig   = soft_q || trig_q || hit;
          trig_q = trig;
          if (!trig) begin
            // pre-trigger ring write, oldest entry overwritten when full
            if (cap_q > 0) begin
              if (fill_q < cap_q) begin
                ring_mem[(head_q + fill_q) % cap_q] = h;
                fill_q++;
              end else begin
                ring_mem[head_q] = h;
                head_q = (head_q + 1) % cap_q;
              end
            end
            if (fill_q == cap_q) stat_q = ST_WRAP;
          end else begin
            // trigger or post-trigger frame, ring flushed once per capture
            stat_q = ST_FLUSH;
            if (!flushed_q) begin
              flushed_q = 1;
              for (i = 0; i < fill_q; i++) begin
                emitted.push_back(ring_mem[(head_q + i) % cap_q]);
              end
              fill_q = 0;
              head_q = 0;
            end
            if (post_q < CNT_MAX) post_q++;
            emitted.push_back(h);
          end
          // end of capture: re-arm or complete
          if (post_q >= post_cfg) begin
            if (caps_q < CNT_MAX) caps_q++;
            if (preset_cfg == 0 || caps_q < preset_cfg) begin
              flushed_q = 0;
              soft_q    = 0;
              trig_q    = 0;
              post_q    = 0;
              stat_q    = ST_FILL;
            end else begin
              trig_q = 0;
              run_q  = 0;
              stat_q = ST_DONE;
            end
          end
        end
      end
    endcase

    // status fields show the state after the whole command
    res.status = stat_q;
    res.fill   = fill_q;
    res.post   = post_q;
    res.caps   = caps_q;
    res.trig   = trig_q;
    if (emitted.size() == 0) begin
      res.valid  = 1'b0;
      res.handle = '0;
      res.last   = 1'b1;
      expected_results.push_back(res);
    end
    for (i = 0; i < emitted.size(); i++) begin
      res.valid  = 1'b1;
      res.handle = emitted[i];
      res.last   = (i == emitted.size() - 1);
      expected_results.push_back(res);
    end
  endtask

  // command driver: one transfer per start & !busy edge
  always @(posedge clk) begin : drive_cmd
    bit        gap;
    cmd_item_t nxt;
    gap = !no_idle && ($urandom_range(0, 99) < 18);
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        capture_predict(cmd, frame_handle, trigger_hit);
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && !gap) begin
          nxt = cmd_backlog.pop_front();
          start        <= 1'b1;
          cmd          <= nxt.op;
          frame_handle <= nxt.handle;
          trigger_hit  <= nxt.hit;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor, sampled mid-cycle while the strobe is up
  always @(negedge clk) begin : check_results
    capture_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, handle %h", out_handle));
      end else begin
        want = expected_results.pop_front();
        check_field("out_valid", out_valid, want.valid);
        check_field("out_handle", out_handle, want.handle);
        check_field("last", last, want.last);
        check_field("status", status, want.status);
        check_field("ring_fill", ring_fill, want.fill);
        check_field("post_done", post_done, want.post);
        check_field("captures_done", captures_done, want.caps);
        check_field("triggered_flag", triggered_flag, want.trig);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PRE_COUNT:  pre_cfg = val[5:0];
      REG_POST_COUNT: post_cfg = val;
      REG_PRESET:     preset_cfg = val;
      default: ;
    endcase
  endtask

  task automatic queue_cmd(cmd_t op, logic [15:0] h, logic hit);
    cmd_item_t item;
    item.op     = op;
    item.handle = h;
    item.hit    = hit;
    cmd_backlog.push_back(item);
  endtask

  function automatic logic [15:0] rand_handle();
    return 16'($urandom_range(0, 65535));
  endfunction

  // armed session: mostly frames, with soft triggers, re-arms, stops and stray commands
  task automatic queue_session(int n, int hit_pct);
    int k;
    int r;
    queue_cmd(CMD_START, rand_handle(), 1'($urandom_range(0, 1)));
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_cmd(CMD_STOP, rand_handle(), 1'($urandom_range(0, 1)));
        queue_cmd(CMD_FRAME, rand_handle(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) begin
          queue_cmd(CMD_SOFT, rand_handle(), 1'($urandom_range(0, 1)));
        end
        queue_cmd(CMD_START, rand_handle(), 1'($urandom_range(0, 1)));
      end else if (r < 6) begin
        queue_cmd(CMD_START, rand_handle(), 1'($urandom_range(0, 1)));
      end else if (r < 11) begin
        queue_cmd(CMD_SOFT, rand_handle(), 1'($urandom_range(0, 1)));
      end else begin
        queue_cmd(CMD_FRAME, rand_handle(), $urandom_range(0, 99) < hit_pct);
      end
    end
  endtask

  // block quiet: nothing queued, nothing in flight, nothing owed
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || busy || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin : run_test
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: commands while stopped, fill and wrap, trigger flush, preset completion
    write_reg(REG_PRE_COUNT, 16'd3);
    write_reg(REG_POST_COUNT, 16'd2);
    write_reg(REG_PRESET, 16'd2);
    @(negedge clk);
    queue_cmd(CMD_FRAME, 16'hffff, 1'b1);
    queue_cmd(CMD_SOFT, 16'h0000, 1'b0);
    queue_cmd(CMD_START, 16'h0000, 1'b0);
    queue_cmd(CMD_FRAME, 16'h0000, 1'b0);
    queue_cmd(CMD_FRAME, 16'hffff, 1'b0);
    queue_cmd(CMD_FRAME, 16'h1234, 1'b0);
    queue_cmd(CMD_FRAME, 16'h8001, 1'b0);
    queue_cmd(CMD_FRAME, 16'h7ffe, 1'b0);
    queue_cmd(CMD_FRAME, 16'haaaa, 1'b1);
    queue_cmd(CMD_FRAME, 16'h5555, 1'b0);
    queue_cmd(CMD_FRAME, 16'h0f0f, 1'b0);
    queue_cmd(CMD_SOFT, 16'hffff, 1'b1);
    queue_cmd(CMD_FRAME, 16'hf0f0, 1'b0);
    queue_cmd(CMD_FRAME, 16'h0001, 1'b0);
    queue_cmd(CMD_FRAME, 16'h8000, 1'b1);
    queue_cmd(CMD_STOP, 16'h0000, 1'b0);
    wait_idle();

    // directed: zero ring capacity and zero post count
    write_reg(REG_PRE_COUNT, 16'd0);
    write_reg(REG_POST_COUNT, 16'd0);
    write_reg(REG_PRESET, 16'd3);
    @(negedge clk);
    queue_cmd(CMD_START, 16'h0000, 1'b0);
    queue_cmd(CMD_FRAME, 16'h1111, 1'b0);
    queue_cmd(CMD_FRAME, 16'h2222, 1'b1);
    queue_cmd(CMD_FRAME, 16'h3333, 1'b0);
    queue_cmd(CMD_STOP, 16'h0000, 1'b0);
    wait_idle();

    // full ring of 63 flushed by one trigger frame, then a random session
    write_reg(REG_PRE_COUNT, 16'd63);
    write_reg(REG_POST_COUNT, 16'd5);
    write_reg(REG_PRESET, 16'd0);
    @(negedge clk);
    queue_cmd(CMD_START, rand_handle(), 1'b0);
    for (k = 0; k < 70; k++) queue_cmd(CMD_FRAME, rand_handle(), 1'b0);
    queue_cmd(CMD_FRAME, rand_handle(), 1'b1);
    queue_session(30, 3);
    wait_idle();

    // single-entry ring, one frame per capture, largest preset
    write_reg(REG_PRE_COUNT, 16'd1);
    write_reg(REG_POST_COUNT, 16'd1);
    write_reg(REG_PRESET, 16'd65535);
    @(negedge clk);
    queue_session(75, 10);
    wait_idle();

    // random settings, back-to-back transfers throughout
    write_reg(REG_PRE_COUNT, 16'($urandom_range(2, 10)));
    write_reg(REG_POST_COUNT, 16'($urandom_range(1, 6)));
    write_reg(REG_PRESET, 16'($urandom_range(1, 4)));
    @(negedge clk);
    no_idle = 1'b1;
    queue_session(75, 8);
    wait_idle();

    // random settings with idling; the spare index must change nothing
    no_idle = 1'b0;
    write_reg(REG_PRE_COUNT, 16'($urandom_range(0, 63)));
    write_reg(REG_POST_COUNT, 16'($urandom_range(1, 12)));
    write_reg(REG_PRESET, 16'($urandom_range(0, 3)));
    write_reg(REG_UNUSED, 16'hffff);
    @(negedge clk);
    queue_session(75, 6);
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
